/* hw/rtl/sirt_pkg.sv */
// ----------------------------------------------------------------------------
// sirt_pkg
// Shared types and codes for the sorted id record table.
// ----------------------------------------------------------------------------
package sirt_pkg;

  localparam int FIELD_W  = 64;
  localparam int STATUS_W = 2;
  localparam int CAP_W    = 7;
  localparam int TOTAL_W  = 7;

  localparam logic [FIELD_W-1:0] NO_DUE_TICK = '1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic [FIELD_W-1:0] id;
    logic [FIELD_W-1:0] start_tick;
    logic [FIELD_W-1:0] interval;
    logic [FIELD_W-1:0] due_tick;
    logic [FIELD_W-1:0] payload;
  } rec_t;

endpackage

/* hw/rtl/sirt_ram.sv */
// ----------------------------------------------------------------------------
// sirt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sirt_ram #(
  parameter int WIDTH = 320,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/sorted_id_record_table.sv */
// ----------------------------------------------------------------------------
// sorted_id_record_table
// Record table kept sorted by ascending 64-bit id, with insert and lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with the in_* fields while busy is low; that edge takes the
//   beat. busy stays high until the result is produced. Each result shows on
//   the out_* ports for exactly one cycle, marked by out_valid; the receiver
//   cannot stall it, and a new command may be taken in that same cycle.
//   cfg_capacity_limit is written on cfg_valid (cfg_ready is always high)
//   and must only change while the block is idle.
// Commands: a full insert, or a lookup on an empty table, is answered from
// idle (busy stays low); an insert on an empty table is the write alone.
//   lookup / duplicate insert: scan, one read per cycle.
//   insert: scan, shift from the top down to the insert position (none on
//   append), then one write. All records live in one RAM with one read and
//   one write port, which sets the scan and shift speed.
// Reset empties the table (count cleared, RAM contents left as they are) and
// sets the capacity limit to 64.
// ----------------------------------------------------------------------------
module sorted_id_record_table
  import sirt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_operation,
  input  logic [FIELD_W-1:0]  in_record_id,
  input  logic [FIELD_W-1:0]  in_start_tick,
  input  logic [FIELD_W-1:0]  in_interval_ticks,
  input  logic [FIELD_W-1:0]  in_due_tick,
  input  logic [FIELD_W-1:0]  in_payload,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_hit,
  output logic [FIELD_W-1:0]  out_found_start_tick,
  output logic [FIELD_W-1:0]  out_found_interval,
  output logic [FIELD_W-1:0]  out_found_due_tick,
  output logic [FIELD_W-1:0]  out_found_payload,
  output logic [TOTAL_W-1:0]  out_entry_total,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CAP_W-1:0]    cfg_capacity_limit
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_WRITE} state_t;

  state_t              state_r, state_nxt;
  logic                op_r, op_nxt;
  rec_t                rec_r, rec_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CAP_W-1:0]    limit_r, limit_nxt;
  logic [CW-1:0]       scan_rd_r, scan_rd_nxt;
  logic [AW-1:0]       chk_idx_r, chk_idx_nxt;
  logic                pend_r, pend_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic [AW-1:0]       sh_rd_r, sh_rd_nxt;
  logic                sh_more_r, sh_more_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                hit_r, hit_nxt;
  logic [FIELD_W-1:0]  f_start_r, f_start_nxt;
  logic [FIELD_W-1:0]  f_intv_r, f_intv_nxt;
  logic [FIELD_W-1:0]  f_due_r, f_due_nxt;
  logic [FIELD_W-1:0]  f_pay_r, f_pay_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  rec_t                ram_wdata;
  logic [AW-1:0]       ram_raddr;
  rec_t                ram_rdata;

  logic [LW-1:0]       lim_eff;
  logic                is_full;
  logic [CW-1:0]       chk_ext;
  logic                id_eq;
  logic                id_gt;
  logic                at_last;

  sirt_ram #(
    .WIDTH($bits(rec_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign lim_eff = (LW'(limit_r) < DEPTH_L) ? LW'(limit_r) : DEPTH_L;
  assign is_full = (LW'(count_r) >= lim_eff);
  assign chk_ext = CW'(chk_idx_r);
  assign id_eq   = pend_r && (ram_rdata.id == rec_r.id);
  assign id_gt   = pend_r && (ram_rdata.id > rec_r.id);
  assign at_last = pend_r && (chk_ext == count_r - CW'(1));

  assign ram_raddr = (state_r == S_SHIFT) ? sh_rd_r : scan_rd_r[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    rec_nxt       = rec_r;
    count_nxt     = count_r;
    limit_nxt     = limit_r;
    scan_rd_nxt   = scan_rd_r;
    chk_idx_nxt   = chk_idx_r;
    pend_nxt      = pend_r;
    pos_nxt       = pos_r;
    sh_rd_nxt     = sh_rd_r;
    sh_more_nxt   = sh_more_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    hit_nxt       = hit_r;
    f_start_nxt   = f_start_r;
    f_intv_nxt    = f_intv_r;
    f_due_nxt     = f_due_r;
    f_pay_nxt     = f_pay_r;
    total_nxt     = total_r;
    ram_we        = 1'b0;
    ram_waddr     = AW'(chk_idx_r + AW'(1));
    ram_wdata     = ram_rdata;

    if (cfg_valid) begin
      limit_nxt = cfg_capacity_limit;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt              = in_operation;
          rec_nxt.id          = in_record_id;
          rec_nxt.start_tick  = in_start_tick;
          rec_nxt.interval    = in_interval_ticks;
          rec_nxt.due_tick    = (in_due_tick == '0 && in_start_tick != '0) ?
                                NO_DUE_TICK : in_due_tick;
          rec_nxt.payload     = in_payload;
          scan_rd_nxt         = '0;
          pend_nxt            = 1'b0;
          if (in_operation == OP_INSERT && is_full) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_FULL;
          end else if (count_r == '0) begin
            if (in_operation == OP_LOOKUP) begin
              out_valid_nxt = 1'b1;
              status_nxt    = ST_MISSING;
            end else begin
              pos_nxt   = '0;
              state_nxt = S_WRITE;
            end
          end else begin
            state_nxt = S_SCAN;
          end
          // result fields without meaning read as zero
          hit_nxt     = 1'b0;
          f_start_nxt = '0;
          f_intv_nxt  = '0;
          f_due_nxt   = '0;
          f_pay_nxt   = '0;
          total_nxt   = TOTAL_W'(count_r);
        end
      end

      S_SCAN: begin
        if (id_eq) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (op_r == OP_INSERT) begin
            status_nxt = ST_DUP;
          end else begin
            status_nxt  = ST_OK;
            hit_nxt     = 1'b1;
            f_start_nxt = ram_rdata.start_tick;
            f_intv_nxt  = ram_rdata.interval;
            f_due_nxt   = ram_rdata.due_tick;
            f_pay_nxt   = ram_rdata.payload;
          end
        end else if (id_gt || at_last) begin
          pos_nxt = id_gt ? chk_ext : count_r;
          if (op_r == OP_LOOKUP) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_MISSING;
            state_nxt     = S_IDLE;
          end else if (!id_gt) begin
            state_nxt = S_WRITE;
          end else begin
            // move entries from the top down to the insert position
            sh_rd_nxt   = AW'(count_r - CW'(1));
            sh_more_nxt = 1'b1;
            pend_nxt    = 1'b0;
            state_nxt   = S_SHIFT;
          end
        end else begin
          pend_nxt    = (scan_rd_r < count_r);
          chk_idx_nxt = scan_rd_r[AW-1:0];
          scan_rd_nxt = scan_rd_r + CW'(1);
        end
      end

      S_SHIFT: begin
        if (pend_r) begin
          ram_we = 1'b1;
        end
        if (sh_more_r) begin
          pend_nxt    = 1'b1;
          chk_idx_nxt = sh_rd_r;
          if (CW'(sh_rd_r) == pos_r) begin
            sh_more_nxt = 1'b0;
          end else begin
            sh_rd_nxt = sh_rd_r - AW'(1);
          end
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_WRITE;
        end
      end

      S_WRITE: begin
        ram_we        = 1'b1;
        ram_waddr     = pos_r[AW-1:0];
        ram_wdata     = rec_r;
        count_nxt     = count_r + CW'(1);
        total_nxt     = TOTAL_W'(count_r + CW'(1));
        out_valid_nxt = 1'b1;
        status_nxt    = ST_OK;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      limit_r     <= CAP_W'(64);
      pend_r      <= 1'b0;
      sh_more_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      limit_r     <= limit_nxt;
      pend_r      <= pend_nxt;
      sh_more_r   <= sh_more_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r      <= op_nxt;
    rec_r     <= rec_nxt;
    scan_rd_r <= scan_rd_nxt;
    chk_idx_r <= chk_idx_nxt;
    pos_r     <= pos_nxt;
    sh_rd_r   <= sh_rd_nxt;
    status_r  <= status_nxt;
    hit_r     <= hit_nxt;
    f_start_r <= f_start_nxt;
    f_intv_r  <= f_intv_nxt;
    f_due_r   <= f_due_nxt;
    f_pay_r   <= f_pay_nxt;
    total_r   <= total_nxt;
  end

  assign busy                 = (state_r != S_IDLE);
  assign cfg_ready            = 1'b1;
  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_hit              = hit_r;
  assign out_found_start_tick = f_start_r;
  assign out_found_interval   = f_intv_r;
  assign out_found_due_tick   = f_due_r;
  assign out_found_payload    = f_pay_r;
  assign out_entry_total      = total_r;

endmodule

/* hw/rtl/sirt_checker.sv */
// ----------------------------------------------------------------------------
// sirt_checker
// Port-level checks for the sorted id record table, bound to the top level.
// ----------------------------------------------------------------------------
module sirt_checker
  import sirt_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic [STATUS_W-1:0] out_status,
  input logic                out_hit,
  input logic [FIELD_W-1:0]  out_found_start_tick,
  input logic [FIELD_W-1:0]  out_found_interval,
  input logic [FIELD_W-1:0]  out_found_due_tick,
  input logic [FIELD_W-1:0]  out_found_payload
);

  // a hit is always reported as ok
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_status == ST_OK)
    else $error("hit with status other than ok");

  // misses and inserts carry zero record fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_found_start_tick == '0 &&
      out_found_interval == '0 && out_found_due_tick == '0 &&
      out_found_payload == '0)
    else $error("record fields nonzero without a hit");

  // every result follows an accepted command or work in progress
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) || $past(start))
    else $error("result without a command");

  // reset leaves the block idle and silent
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("busy or result right after reset");

endmodule

bind sorted_id_record_table sirt_checker u_sirt_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .out_valid            (out_valid),
  .out_status           (out_status),
  .out_hit              (out_hit),
  .out_found_start_tick (out_found_start_tick),
  .out_found_interval   (out_found_interval),
  .out_found_due_tick   (out_found_due_tick),
  .out_found_payload    (out_found_payload)
);
